### design/delta_list_sleep_queue_defines.svh
// Assertion macros used by the checker file.
`ifndef DELTA_LIST_SLEEP_QUEUE_DEFINES_SVH
`define DELTA_LIST_SLEEP_QUEUE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DLSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlsq: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define DLSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlsq: next-cycle check failed");

`endif

### design/dlsq_pkg.sv
package dlsq_pkg;

  localparam int TASK_ID_W   = 8;
  localparam int DELAY_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_WOKEN = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT,
    S_SHIFT_END,
    S_INSERT,
    S_DEC,
    S_CHK,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ADD,
    DP_REJECT,
    DP_TICK,
    DP_WALK,
    DP_SHIFT,
    DP_SHIFT_END,
    DP_INSERT,
    DP_DEC,
    DP_CHK,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e rej_code;
  } dl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic delay_zero;
    logic le;
    logic walk_end;
    logic at_pos;
    logic dec_zero;
    logic last_pop;
    logic slot_free;
    logic hold_last;
  } dl_stat_t;

endpackage

### design/dlsq_ctrl.sv
module dlsq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dlsq_pkg::opcode_e  in_opcode_i,
  input  dlsq_pkg::dl_stat_t stat_i,
  output logic               in_ready_o,
  output dlsq_pkg::dl_cmd_t  cmd_o
);
  import dlsq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.op        = DP_NOP;
    cmd_o.rej_code  = ST_WOKEN;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_ADD) begin
            priority if (stat_i.delay_zero) begin
              cmd_o.op       = DP_REJECT;
              cmd_o.rej_code = ST_ZERO;
              state_d        = S_EMIT;
            end else if (stat_i.full) begin
              cmd_o.op       = DP_REJECT;
              cmd_o.rej_code = ST_FULL;
              state_d        = S_EMIT;
            end else begin
              cmd_o.op = DP_ADD;
              state_d  = stat_i.empty ? S_INSERT : S_WALK;
            end
          end else begin
            cmd_o.op = DP_TICK;
            state_d  = stat_i.empty ? S_IDLE : S_DEC;
          end
        end
      end
      S_WALK: begin
        cmd_o.op = DP_WALK;
        if (!stat_i.le) begin
          state_d = S_SHIFT;
        end else if (stat_i.walk_end) begin
          state_d = S_INSERT;
        end
      end
      S_SHIFT: begin
        cmd_o.op = DP_SHIFT;
        if (stat_i.at_pos) begin
          state_d = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        cmd_o.op = DP_SHIFT_END;
        state_d  = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.op = DP_INSERT;
        state_d  = S_IDLE;
      end
      S_DEC: begin
        cmd_o.op = DP_DEC;
        if (stat_i.dec_zero) begin
          state_d = stat_i.last_pop ? S_EMIT : S_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        cmd_o.op = DP_CHK;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = DP_EMIT;
        if (stat_i.slot_free) begin
          if (stat_i.hold_last) begin
            state_d = S_IDLE;
          end else begin
            // next head already popped into the hold stage
            state_d = stat_i.last_pop ? S_EMIT : S_CHK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### design/dlsq_datapath.sv
module dlsq_datapath #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dlsq_pkg::TASK_ID_W-1:0]   in_task_id_i,
  input  logic [dlsq_pkg::DELAY_W-1:0]     in_delay_i,
  input  dlsq_pkg::dl_cmd_t                cmd_i,
  output dlsq_pkg::dl_stat_t               stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [dlsq_pkg::TASK_ID_W-1:0]   out_task_o,
  output logic [dlsq_pkg::STATUS_W-1:0]    out_status_o,
  output logic                             out_last_o
);
  import dlsq_pkg::*;

  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int IDW = TASK_ID_BITS;

  // logical slot -> physical address of the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [DELAY_W-1:0] mem_delay [QUEUE_DEPTH];
  logic [IDW-1:0]     mem_id    [QUEUE_DEPTH];

  logic               re, we;
  logic [AW-1:0]      raddr, waddr;
  logic [DELAY_W-1:0] wdelay;
  logic [IDW-1:0]     wid;
  logic [DELAY_W-1:0] rd_delay_q;
  logic [IDW-1:0]     rd_id_q;

  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      widx_q, widx_d;
  logic               fix_q, fix_d;
  logic               wr_pend_q, wr_pend_d;
  logic [DELAY_W-1:0] rem_q, rem_d;
  logic [IDW-1:0]     newid_q, newid_d;
  logic [IDW-1:0]     hold_id_q, hold_id_d;
  status_e            hold_status_q, hold_status_d;
  logic               hold_last_q, hold_last_d;
  logic               out_valid_q, out_valid_d;
  logic [TASK_ID_W-1:0] out_task_q, out_task_d;
  status_e            out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic               le, slot_free, dec_zero;
  logic [DELAY_W-1:0] dec_val;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_delay[waddr] <= wdelay;
      mem_id[waddr]    <= wid;
    end
    if (re) begin
      rd_delay_q <= mem_delay[raddr];
      rd_id_q    <= mem_id[raddr];
    end
  end

  assign le        = (rd_delay_q <= rem_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign dec_zero  = (rd_delay_q <= DELAY_W'(1));
  assign dec_val   = (rd_delay_q == '0) ? '0 : rd_delay_q - DELAY_W'(1);

  always_comb begin
    stat_o.empty      = (count_q == '0);
    stat_o.full       = (count_q == CW'(QUEUE_DEPTH));
    stat_o.delay_zero = (in_delay_i == '0);
    stat_o.le         = le;
    stat_o.walk_end   = ((idx_q + CW'(1)) == count_q);
    stat_o.at_pos     = (idx_q == pos_q);
    stat_o.dec_zero   = dec_zero;
    stat_o.last_pop   = (count_q == CW'(1));
    stat_o.slot_free  = slot_free;
    stat_o.hold_last  = hold_last_q;
  end

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    widx_d        = widx_q;
    fix_d         = fix_q;
    wr_pend_d     = wr_pend_q;
    rem_d         = rem_q;
    newid_d       = newid_q;
    hold_id_d     = hold_id_q;
    hold_status_d = hold_status_q;
    hold_last_d   = hold_last_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_task_d    = out_task_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;
    re            = 1'b0;
    raddr         = head_q;
    we            = 1'b0;
    waddr         = head_q;
    wdelay        = rd_delay_q;
    wid           = rd_id_q;

    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_ADD: begin
        rem_d   = in_delay_i;
        newid_d = IDW'(in_task_id_i);
        idx_d   = '0;
        pos_d   = '0;
        re      = 1'b1;
      end
      DP_REJECT: begin
        hold_id_d     = IDW'(in_task_id_i);
        hold_status_d = cmd_i.rej_code;
        hold_last_d   = 1'b1;
      end
      DP_TICK: begin
        re = 1'b1;
      end
      DP_WALK: begin
        // the read for the following slot goes out speculatively
        re        = 1'b1;
        raddr     = phys(head_q, idx_q + CW'(1));
        wr_pend_d = 1'b0;
        if (le) begin
          rem_d = rem_q - rd_delay_q;
          idx_d = idx_q + CW'(1);
          pos_d = idx_q + CW'(1);
        end else begin
          pos_d = idx_q;
          idx_d = count_q - CW'(1);
        end
      end
      DP_SHIFT: begin
        we        = wr_pend_q;
        waddr     = phys(head_q, widx_q);
        wdelay    = fix_q ? rd_delay_q - rem_q : rd_delay_q;
        re        = 1'b1;
        raddr     = phys(head_q, idx_q);
        widx_d    = idx_q + CW'(1);
        fix_d     = (idx_q == pos_q);
        wr_pend_d = 1'b1;
        if (idx_q != pos_q) begin
          idx_d = idx_q - CW'(1);
        end
      end
      DP_SHIFT_END: begin
        we        = wr_pend_q;
        waddr     = phys(head_q, widx_q);
        wdelay    = fix_q ? rd_delay_q - rem_q : rd_delay_q;
        wr_pend_d = 1'b0;
      end
      DP_INSERT: begin
        we      = 1'b1;
        waddr   = phys(head_q, pos_q);
        wdelay  = rem_q;
        wid     = newid_q;
        count_d = count_q + CW'(1);
      end
      DP_DEC: begin
        we     = 1'b1;
        wdelay = dec_val;
        if (dec_zero) begin
          hold_id_d     = rd_id_q;
          hold_status_d = ST_WOKEN;
          hold_last_d   = (count_q == CW'(1));
          head_d        = phys(head_q, CW'(1));
          count_d       = count_q - CW'(1);
          re            = (count_q != CW'(1));
          raddr         = phys(head_q, CW'(1));
        end
      end
      DP_CHK: begin
        // the held task is last unless the next one also has zero delta
        hold_last_d = (rd_delay_q != '0);
      end
      DP_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_task_d   = TASK_ID_W'(hold_id_q);
          out_status_d = hold_status_q;
          out_last_d   = hold_last_q;
          if (!hold_last_q) begin
            hold_id_d     = rd_id_q;
            hold_status_d = ST_WOKEN;
            hold_last_d   = (count_q == CW'(1));
            head_d        = phys(head_q, CW'(1));
            count_d       = count_q - CW'(1);
            re            = (count_q != CW'(1));
            raddr         = phys(head_q, CW'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    pos_q         <= pos_d;
    widx_q        <= widx_d;
    fix_q         <= fix_d;
    rem_q         <= rem_d;
    newid_q       <= newid_d;
    hold_id_q     <= hold_id_d;
    hold_status_q <= hold_status_d;
    hold_last_q   <= hold_last_d;
    out_task_q    <= out_task_d;
    out_status_q  <= out_status_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_task_o   = out_task_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

### design/delta_list_sleep_queue.sv
// Sleep queue held as a delta list in a single-port-read circular store of
// QUEUE_DEPTH entries. A request is either an add (task id plus delay) or a
// timer tick. An add walks the list one entry per cycle, then moves the tail
// entries up one slot per cycle and writes the newcomer; the memory's one
// read and one write per cycle set that pace. An accepted add gives no
// result; a zero delay or a full queue gives one rejection result. A tick
// decrements the head delta; each woken task is popped into a hold stage,
// the following delta is read to see whether it wakes too (not when the
// list empties), and the task is emitted once the output register is free,
// so an output stall holds the tick. Woken
// tasks leave in wake order, tlast on the final one. One request is handled at
// a time; the next is accepted once the previous one has finished, while its
// last result may still sit in the output register.
module delta_list_sleep_queue #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] task_id, [39:8] delay_ticks
  input  logic [dlsq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] opcode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] woken_task
  output logic [dlsq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [1:0] status
  output logic [dlsq_pkg::STATUS_W-1:0]       m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import dlsq_pkg::*;

  dl_cmd_t  cmd;
  dl_stat_t stat;

  dlsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (opcode_e'(s_axis_tuser_i)),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  dlsq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_task_id_i (s_axis_tdata_i[TASK_ID_W-1:0]),
    .in_delay_i   (s_axis_tdata_i[TASK_ID_W+DELAY_W-1:TASK_ID_W]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_task_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

### design/dlsq_checker.sv
`include "delta_list_sleep_queue_defines.svh"

module dlsq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [dlsq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input logic                                s_axis_tuser_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [dlsq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input logic [dlsq_pkg::STATUS_W-1:0]       m_axis_tuser_o,
  input logic                                m_axis_tlast_o
);
  import dlsq_pkg::*;

  logic add_req;
  logic zero_add;
  logic zero_out;
  logic out_stall;
  logic [OUT_TDATA_W+STATUS_W:0] out_bus;

  assign add_req = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_ADD);
  assign zero_add = add_req && !m_axis_tvalid_o &&
                    (s_axis_tdata_i[TASK_ID_W+DELAY_W-1:TASK_ID_W] == '0);
  assign zero_out = m_axis_tvalid_o && (m_axis_tuser_o == ST_ZERO) && m_axis_tlast_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_bus   = {m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o};

  // an accepted add always leaves the block busy, with ready low
  `DLSQ_ASSERT_NEXT(a_add_busy, clk_i, rst_ni, add_req, !s_axis_tready_o)

  // zero-delay add into an empty output passes its rejection through the hold stage, then the output register
  `DLSQ_ASSERT_NEXT(a_zero_reject, clk_i, rst_ni, zero_add, ##1 zero_out)

  // a rejection is a run of one
  `DLSQ_ASSERT_NOW(a_reject_last, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != ST_WOKEN), m_axis_tlast_o)

  `DLSQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_bus))

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
